[rtl/hts_pkg.sv]
// html tag stripper: shared types, match patterns and helper functions
// no dependencies; used by hts_window, hts_decide and html_tag_stripper_core
package hts_pkg;

	// default lookahead depth and the number of bytes the decision looks at
	localparam int HTS_WINDOW_BYTES = 10;
	localparam int HTS_LOOK_BYTES   = 10;

	// byte width of the stream and the skip counter width
	localparam int HTS_BYTE_W = 8;
	localparam int HTS_SKIP_W = 4;

	// bytes still dropped after a closing script or style tag
	localparam logic [HTS_SKIP_W-1:0] HTS_SKIP_SCRIPT = 4'd8;
	localparam logic [HTS_SKIP_W-1:0] HTS_SKIP_STYLE  = 4'd7;

	// characters the decision tests against
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_LO_P  = 8'h70;
	localparam logic [7:0] CH_UP_P  = 8'h50;
	localparam logic [7:0] CH_LO_H  = 8'h68;
	localparam logic [7:0] CH_UP_H  = 8'h48;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_LO_R  = 8'h72;
	localparam logic [7:0] CH_LO_D  = 8'h64;
	localparam logic [7:0] CH_LO_I  = 8'h69;
	localparam logic [7:0] CH_LO_V  = 8'h76;

	// match patterns, element 0 is the first character
	localparam int OPEN_SCRIPT_LEN  = 7;
	localparam int CLOSE_SCRIPT_LEN = 9;
	localparam int OPEN_STYLE_LEN   = 6;
	localparam int CLOSE_STYLE_LEN  = 8;

	localparam logic [OPEN_SCRIPT_LEN-1:0][7:0] PAT_OPEN_SCRIPT =
		{"t", "p", "i", "r", "c", "s", "<"};
	localparam logic [CLOSE_SCRIPT_LEN-1:0][7:0] PAT_CLOSE_SCRIPT =
		{">", "t", "p", "i", "r", "c", "s", "/", "<"};
	localparam logic [OPEN_STYLE_LEN-1:0][7:0] PAT_OPEN_STYLE =
		{"e", "l", "y", "t", "s", "<"};
	localparam logic [CLOSE_STYLE_LEN-1:0][7:0] PAT_CLOSE_STYLE =
		{">", "e", "l", "y", "t", "s", "/", "<"};

	// class of the last emitted text byte
	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_NEWLINE,
		CLS_SPACE,
		CLS_OTHER
	} hts_class_t;

	// parser state carried from one decision to the next
	typedef struct packed {
		logic [HTS_SKIP_W-1:0] skip;
		logic                  inside_tag;
		logic                  inside_script;
		logic                  inside_style;
		hts_class_t            last_class;
	} hts_flags_t;

	// result of deciding the head byte
	typedef struct packed {
		hts_flags_t            next;
		logic                  emit;
		logic [HTS_BYTE_W-1:0] text;
	} hts_dec_t;

	// ascii upper case to lower case
	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	// class of an emitted byte
	function automatic hts_class_t class_of(input logic [7:0] c);
		hts_class_t r;
		r = CLS_OTHER;
		if (c == CH_NL) begin
			r = CLS_NEWLINE;
		end else if (c == CH_SPACE) begin
			r = CLS_SPACE;
		end
		return r;
	endfunction

endpackage

[rtl/html_tag_stripper_core.sv]
// html tag stripper top level: input handshake, flush control, output register
// depends on hts_pkg, hts_window and hts_decide
//
//  channel  dir  data                        tuser         tlast
//  s_       in   tdata[7:0] in_byte          -             in_last
//  m_       out  tdata[7:0] out_byte         out_valid     out_last
//
// one request per cycle in steady state while the m_ side is not stalled; the head
// byte is decided once the window holds WINDOW_BYTES bytes, one decision per cycle
// through hts_decide. a request with tlast starts a flush: up to WINDOW_BYTES decisions,
// then the end marker, with s_tready low until the end marker is issued.
// reset clears the fill count and the parser state; window bytes are not reset.
// a stalled m_ side holds the result register and stops decisions.
module html_tag_stripper_core #(
	parameter int WINDOW_BYTES = hts_pkg::HTS_WINDOW_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] out_valid
	output logic       m_tlast
);

	localparam int FILL_W = $clog2(WINDOW_BYTES + 1);

	localparam hts_pkg::hts_flags_t FLAGS_RESET = '{
		skip:          '0,
		inside_tag:    1'b0,
		inside_script: 1'b0,
		inside_style:  1'b0,
		last_class:    hts_pkg::CLS_NONE
	};

	logic [WINDOW_BYTES-1:0][hts_pkg::HTS_BYTE_W-1:0] win;
	logic [FILL_W-1:0]                                fill;
	hts_pkg::hts_flags_t                              flags_q;
	hts_pkg::hts_dec_t                                dec;
	logic                                             flush_q;
	logic                                             out_free;
	logic                                             full;
	logic                                             dec_go;
	logic                                             end_go;
	logic                                             push;
	logic                                             m_tvalid_q;
	logic [7:0]                                       m_tdata_q;
	logic                                             m_tuser_q;
	logic                                             m_tlast_q;

	// handshake and decision control
	assign out_free = !m_tvalid_q || m_tready;
	assign full     = fill == FILL_W'(WINDOW_BYTES);
	assign dec_go   = out_free && (flush_q ? (fill != '0) : full);
	assign end_go   = out_free && flush_q && (fill == '0);
	assign s_tready = !flush_q && (!full || out_free);
	assign push     = s_tvalid && s_tready;

	hts_window #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.FILL_W      (FILL_W)
	) u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (dec_go),
		.din   (s_tdata),
		.win   (win),
		.fill  (fill)
	);

	hts_decide #(
		.WINDOW_BYTES(WINDOW_BYTES),
		.FILL_W      (FILL_W)
	) u_decide (
		.win  (win),
		.fill (fill),
		.flags(flags_q),
		.dec  (dec)
	);

	// parser state and flush flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= FLAGS_RESET;
			flush_q <= 1'b0;
		end else begin
			if (dec_go) begin
				flags_q <= dec.next;
			end else if (end_go) begin
				flags_q <= FLAGS_RESET;
			end
			if (push && s_tlast) begin
				flush_q <= 1'b1;
			end else if (end_go) begin
				flush_q <= 1'b0;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((dec_go && dec.emit) || end_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (dec_go && dec.emit) begin
			m_tdata_q <= dec.text;
			m_tuser_q <= 1'b1;
			m_tlast_q <= 1'b0;
		end else if (end_go) begin
			m_tdata_q <= '0;
			m_tuser_q <= 1'b0;
			m_tlast_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

[rtl/hts_window.sv]
// lookahead window: shift register of markup bytes with a fill count
// depends on hts_pkg
module hts_window #(
	parameter int WINDOW_BYTES = hts_pkg::HTS_WINDOW_BYTES,
	parameter int FILL_W       = $clog2(WINDOW_BYTES + 1)
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            push,
	input  logic                                            pop,
	input  logic [hts_pkg::HTS_BYTE_W-1:0]                  din,
	output logic [WINDOW_BYTES-1:0][hts_pkg::HTS_BYTE_W-1:0] win,
	output logic [FILL_W-1:0]                               fill
);

	logic [WINDOW_BYTES-1:0][hts_pkg::HTS_BYTE_W-1:0] win_q;
	logic [WINDOW_BYTES-1:0][hts_pkg::HTS_BYTE_W-1:0] win_d;
	logic [FILL_W-1:0]                                fill_q;
	logic [FILL_W-1:0]                                wr_pos;

	// slot the new byte lands in, after a possible shift
	assign wr_pos = pop ? (fill_q - FILL_W'(1)) : fill_q;

	// shift on pop, write the new byte on push
	always_comb begin
		win_d = win_q;
		if (pop) begin
			for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
				win_d[i] = win_q[i + 1];
			end
		end
		if (push) begin
			for (int i = 0; i < WINDOW_BYTES; i++) begin
				if (FILL_W'(i) == wr_pos) begin
					win_d[i] = din;
				end
			end
		end
	end

	// window bytes hold no reset; only filled entries are looked at
	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push && !pop) begin
			fill_q <= fill_q + FILL_W'(1);
		end else if (pop && !push) begin
			fill_q <= fill_q - FILL_W'(1);
		end
	end

	assign win  = win_q;
	assign fill = fill_q;

endmodule

[rtl/hts_decide.sv]
// head-byte decision: tag, script and style tracking and block-tag newlines
// depends on hts_pkg; purely combinational
module hts_decide #(
	parameter int WINDOW_BYTES = hts_pkg::HTS_WINDOW_BYTES,
	parameter int FILL_W       = $clog2(WINDOW_BYTES + 1)
) (
	input  logic [WINDOW_BYTES-1:0][hts_pkg::HTS_BYTE_W-1:0] win,
	input  logic [FILL_W-1:0]                               fill,
	input  hts_pkg::hts_flags_t                             flags,
	output hts_pkg::hts_dec_t                               dec
);

	localparam int LOOK = hts_pkg::HTS_LOOK_BYTES;

	logic [LOOK-1:0] hv;
	logic [7:0]      c;
	logic [7:0]      n1;
	logic [7:0]      n2;
	logic [7:0]      n3;
	logic            m_open_script;
	logic            m_open_style;
	logic            m_close_script;
	logic            m_close_style;
	logic            in_body;
	logic            block_tag;

	// which window slots hold real bytes
	always_comb begin
		for (int k = 0; k < LOOK; k++) begin
			hv[k] = fill > FILL_W'(k);
		end
	end

	assign c  = win[0];
	assign n1 = win[1];
	assign n2 = win[2];
	assign n3 = win[3];

	// case-insensitive pattern matches over the window
	always_comb begin
		m_open_script = hv[8] && (win[7] == hts_pkg::CH_GT || win[7] == hts_pkg::CH_SPACE);
		for (int k = 0; k < hts_pkg::OPEN_SCRIPT_LEN; k++) begin
			m_open_script &= hv[k] && (hts_pkg::to_lower(win[k]) == hts_pkg::PAT_OPEN_SCRIPT[k]);
		end
		m_open_style = hv[8] && (win[6] == hts_pkg::CH_GT || win[6] == hts_pkg::CH_SPACE);
		for (int k = 0; k < hts_pkg::OPEN_STYLE_LEN; k++) begin
			m_open_style &= hv[k] && (hts_pkg::to_lower(win[k]) == hts_pkg::PAT_OPEN_STYLE[k]);
		end
		m_close_script = hv[9];
		for (int k = 0; k < hts_pkg::CLOSE_SCRIPT_LEN; k++) begin
			m_close_script &= hv[k] &&
				(hts_pkg::to_lower(win[k]) == hts_pkg::PAT_CLOSE_SCRIPT[k]);
		end
		m_close_style = hv[9];
		for (int k = 0; k < hts_pkg::CLOSE_STYLE_LEN; k++) begin
			m_close_style &= hv[k] && (hts_pkg::to_lower(win[k]) == hts_pkg::PAT_CLOSE_STYLE[k]);
		end
	end

	// p, h, br or div right after the '<'
	assign block_tag = hv[2] && (
		n1 == hts_pkg::CH_LO_P || n1 == hts_pkg::CH_UP_P ||
		n1 == hts_pkg::CH_LO_H || n1 == hts_pkg::CH_UP_H ||
		(n1 == hts_pkg::CH_LO_B && n2 == hts_pkg::CH_LO_R) ||
		(n1 == hts_pkg::CH_LO_D && n2 == hts_pkg::CH_LO_I && hv[3] && n3 == hts_pkg::CH_LO_V));

	assign in_body = flags.inside_script || flags.inside_style;

	// priority decision on the head byte; the head always leaves the window, emitted or not
	always_comb begin
		dec.next = flags;
		dec.emit = 1'b0;
		dec.text = c;
		if (flags.skip != '0) begin
			dec.next.skip = flags.skip - 4'd1;
		end else if (!flags.inside_tag && m_open_script) begin
			dec.next.inside_script = 1'b1;
			dec.next.inside_tag    = 1'b1;
		end else if (!flags.inside_tag && m_open_style) begin
			dec.next.inside_style = 1'b1;
			dec.next.inside_tag   = 1'b1;
		end else if (flags.inside_script && m_close_script) begin
			dec.next.inside_script = 1'b0;
			dec.next.inside_tag    = 1'b0;
			dec.next.skip          = hts_pkg::HTS_SKIP_SCRIPT;
		end else if (flags.inside_style && m_close_style) begin
			dec.next.inside_style = 1'b0;
			dec.next.inside_tag   = 1'b0;
			dec.next.skip         = hts_pkg::HTS_SKIP_STYLE;
		end else if (in_body) begin
			dec.emit = 1'b0;
		end else if (c == hts_pkg::CH_LT) begin
			dec.next.inside_tag = 1'b1;
			if (block_tag && flags.last_class == hts_pkg::CLS_OTHER) begin
				dec.emit = 1'b1;
				dec.text = hts_pkg::CH_NL;
			end
		end else if (c == hts_pkg::CH_GT) begin
			dec.next.inside_tag = 1'b0;
		end else if (!flags.inside_tag) begin
			dec.emit = 1'b1;
		end
		if (dec.emit) begin
			dec.next.last_class = hts_pkg::class_of(dec.text);
		end
	end

endmodule

[bench/tb_html_tag_stripper_core.sv]
// self-checking bench for html_tag_stripper_core: markup documents in, plain text out
// depends on hts_pkg (class enum) and the rtl of html_tag_stripper_core
// a local predictor tracks the lookahead window and parser flags per request
module tb_html_tag_stripper_core;

	localparam int WIN = 10;

	// characters the predictor looks for
	localparam logic [7:0] ASC_LT = 8'h3C;
	localparam logic [7:0] ASC_GT = 8'h3E;
	localparam logic [7:0] ASC_SP = 8'h20;
	localparam logic [7:0] ASC_NL = 8'h0A;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] in_byte
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] out_byte
	logic       m_tuser;   // [0] out_valid
	logic       m_tlast;

	// one expected result
	typedef struct packed {
		logic [7:0] text;
		logic       vld;
		logic       lst;
	} text_rec_t;

	// directed request, with a typed result for single-byte documents
	typedef struct {
		logic [7:0] b;
		bit         l;
		bit         typed;
		logic [7:0] exp;
	} dir_row_t;

	text_rec_t text_due[$];
	int        n_taken = 0;
	int        n_faults = 0;
	int        calm_left = 0;
	bit        dir_typed;
	logic [7:0] dir_exp;
	logic [7:0] doc[$];

	// predictor state
	logic [7:0]         win[WIN];
	int                 fill = 0;
	logic [3:0]         skip = '0;
	bit                 in_tag = 0;
	bit                 script_on = 0;
	bit                 style_on = 0;
	hts_pkg::hts_class_t last_cls = hts_pkg::CLS_NONE;

	string tag_kinds[14] = '{"<p>", "<P>", "<h2>", "<H1>", "<br>", "<BR>", "<div>", "<dIv>",
		"<di>", "<b>", "<d>", "</p>", "<a href=x>", "<scriptx>"};

	// extremes, a br break, and an upper-case style block closed near the end
	dir_row_t dir_rows[25] = '{
		'{8'h00, 1'b1, 1'b1, 8'h00},
		'{8'hFF, 1'b1, 1'b1, 8'hFF},
		'{"a", 1'b0, 1'b0, 8'h00}, '{"<", 1'b0, 1'b0, 8'h00},
		'{"b", 1'b0, 1'b0, 8'h00}, '{"r", 1'b0, 1'b0, 8'h00},
		'{">", 1'b0, 1'b0, 8'h00}, '{"b", 1'b1, 1'b0, 8'h00},
		'{"<", 1'b0, 1'b0, 8'h00}, '{"S", 1'b0, 1'b0, 8'h00},
		'{"T", 1'b0, 1'b0, 8'h00}, '{"Y", 1'b0, 1'b0, 8'h00},
		'{"L", 1'b0, 1'b0, 8'h00}, '{"E", 1'b0, 1'b0, 8'h00},
		'{">", 1'b0, 1'b0, 8'h00}, '{"x", 1'b0, 1'b0, 8'h00},
		'{"<", 1'b0, 1'b0, 8'h00}, '{"/", 1'b0, 1'b0, 8'h00},
		'{"s", 1'b0, 1'b0, 8'h00}, '{"t", 1'b0, 1'b0, 8'h00},
		'{"y", 1'b0, 1'b0, 8'h00}, '{"l", 1'b0, 1'b0, 8'h00},
		'{"e", 1'b0, 1'b0, 8'h00}, '{">", 1'b0, 1'b0, 8'h00},
		'{"y", 1'b1, 1'b0, 8'h00}
	};

	html_tag_stripper_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// window entry k is present
	function automatic bit held(input int k);
		return k < fill && k < WIN;
	endfunction

	function automatic logic [7:0] peek(input int k);
		return held(k) ? win[k] : 8'h00;
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// case-insensitive match from the head; absent bytes never match
	function automatic bit match_ci(input string pat);
		for (int k = 0; k < pat.len(); k++) begin
			if (!held(k) || fold(peek(k)) != pat[k]) begin
				return 0;
			end
		end
		return 1;
	endfunction

	task automatic drop_head();
		if (fill == 0) begin
			return;
		end
		for (int k = 0; k < WIN - 1; k++) begin
			win[k] = win[k + 1];
		end
		win[WIN - 1] = 8'h00;
		fill--;
	endtask

	task automatic emit_text(input logic [7:0] c);
		text_due.push_back('{c, 1'b1, 1'b0});
		if (c == ASC_NL) begin
			last_cls = hts_pkg::CLS_NEWLINE;
		end else if (c == ASC_SP) begin
			last_cls = hts_pkg::CLS_SPACE;
		end else begin
			last_cls = hts_pkg::CLS_OTHER;
		end
	endtask

	// decide the byte at the head of the window
	task automatic decide_head();
		logic [7:0] c;
		logic [7:0] n1;
		logic [7:0] n2;
		logic [7:0] n3;
		c = peek(0);
		if (skip > 0) begin
			skip = skip - 4'd1;
			drop_head();
			return;
		end
		// opening script or style needs nine bytes present
		if (!in_tag && held(8)) begin
			if (match_ci("<script") && (peek(7) == ASC_GT || peek(7) == ASC_SP)) begin
				script_on = 1;
				in_tag = 1;
				drop_head();
				return;
			end
			if (match_ci("<style") && (peek(6) == ASC_GT || peek(6) == ASC_SP)) begin
				style_on = 1;
				in_tag = 1;
				drop_head();
				return;
			end
		end
		// closing tag needs ten bytes present, also leaves tag mode
		if ((script_on || style_on) && held(9)) begin
			if (script_on && match_ci("</script>")) begin
				script_on = 0;
				in_tag = 0;
				skip = 4'd8;
				drop_head();
				return;
			end
			if (style_on && match_ci("</style>")) begin
				style_on = 0;
				in_tag = 0;
				skip = 4'd7;
				drop_head();
				return;
			end
		end
		if (script_on || style_on) begin
			drop_head();
			return;
		end
		// tag start, with a line break ahead of block tags
		if (c == ASC_LT) begin
			in_tag = 1;
			if (held(2)) begin
				n1 = peek(1);
				n2 = peek(2);
				n3 = peek(3);
				if (n1 == "p" || n1 == "P" || n1 == "h" || n1 == "H" ||
						(n1 == "b" && n2 == "r") ||
						(n1 == "d" && n2 == "i" && held(3) && n3 == "v")) begin
					if (last_cls == hts_pkg::CLS_OTHER) begin
						emit_text(ASC_NL);
					end
				end
			end
			drop_head();
			return;
		end
		if (c == ASC_GT) begin
			in_tag = 0;
			drop_head();
			return;
		end
		if (in_tag) begin
			drop_head();
			return;
		end
		emit_text(c);
		drop_head();
	endtask

	// expected results of one accepted request
	task automatic strip_step(input logic [7:0] b, input bit l);
		if (fill < WIN) begin
			win[fill] = b;
			fill++;
		end
		if (!l) begin
			if (fill >= WIN) begin
				decide_head();
			end
		end else begin
			while (fill > 0) begin
				decide_head();
			end
			text_due.push_back('{8'h00, 1'b0, 1'b1});
			skip = '0;
			in_tag = 0;
			script_on = 0;
			style_on = 0;
			last_cls = hts_pkg::CLS_NONE;
		end
	endtask

	// predict on accepted requests, compare accepted results
	always @(posedge clk) begin
		int        n0;
		text_rec_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				n0 = text_due.size();
				strip_step(s_tdata, s_tlast);
				n_taken++;
				if (dir_typed) begin
					while (text_due.size() > n0) begin
						text_due.delete(text_due.size() - 1);
					end
					text_due.push_back('{dir_exp, 1'b1, 1'b0});
					text_due.push_back('{8'h00, 1'b0, 1'b1});
				end
			end
			if (m_tvalid && m_tready) begin
				if (text_due.size() == 0) begin
					$error("unexpected result: out_byte %02h out_valid %0b out_last %0b",
						m_tdata, m_tuser, m_tlast);
					n_faults++;
				end else begin
					want = text_due.pop_front();
					if (m_tdata !== want.text) begin
						$error("out_byte: expected %02h, got %02h", want.text, m_tdata);
						n_faults++;
					end
					if (m_tuser !== want.vld) begin
						$error("out_valid: expected %0b, got %0b", want.vld, m_tuser);
						n_faults++;
					end
					if (m_tlast !== want.lst) begin
						$error("out_last: expected %0b, got %0b", want.lst, m_tlast);
						n_faults++;
					end
				end
			end
		end
	end

	// idle cycles before the next request, with calm stretches
	function automatic int next_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(10, 30);
	endfunction

	task automatic send(input logic [7:0] b, input bit l, input bit typed,
			input logic [7:0] exp);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= b;
		s_tlast   <= l;
		dir_typed <= typed;
		dir_exp   <= exp;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// append a string, optionally flipping letters to upper case
	task automatic add_text(input string s, input bit mix);
		logic [7:0] ch;
		for (int k = 0; k < s.len(); k++) begin
			ch = s[k];
			if (mix && ch >= "a" && ch <= "z" && $urandom_range(0, 2) == 0) begin
				ch = ch - 8'd32;
			end
			doc.push_back(ch);
		end
	endtask

	// receiver: bursts and stalls, plus one long hold-off to back up the block
	initial begin
		int len;
		int r;
		bit rdy;
		bit hold_done;
		hold_done = 0;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!hold_done && n_taken >= 120) begin
				hold_done = 1;
				rdy = 0;
				len = 300;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					rdy = 1;
					len = $urandom_range(1, 30);
				end else if (r < 92) begin
					rdy = 0;
					len = $urandom_range(1, 3);
				end else begin
					rdy = 0;
					len = $urandom_range(10, 40);
				end
			end
			m_tready <= rdy;
			repeat (len) @(posedge clk);
		end
	end

	// sender: directed rows, then random documents
	initial begin
		int n_rand;
		int goal;
		logic [7:0] ch;
		n_rand = 0;
		arst_n = 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'h00;
		s_tlast   <= 1'b0;
		dir_typed <= 1'b0;
		dir_exp   <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].exp);
		end

		while (n_rand < 300) begin
			doc.delete();
			if ($urandom_range(0, 99) < 12) begin
				// very short documents: everything decided in the flush
				repeat ($urandom_range(1, 3)) doc.push_back(8'($urandom_range(0, 255)));
			end else begin
				goal = $urandom_range(8, 45);
				while (doc.size() < goal) begin
					case ($urandom_range(0, 15))
						4: add_text(" ", 0);
						5: add_text("\n", 0);
						6: add_text(tag_kinds[$urandom_range(0, 13)], 0);
						7: begin
							add_text($urandom_range(0, 1) ? "<script>" : "<script ", 1);
							repeat ($urandom_range(0, 12))
								doc.push_back(8'($urandom_range(32, 126)));
							add_text("</script>", $urandom_range(0, 3) == 0);
						end
						8: begin
							add_text($urandom_range(0, 1) ? "<style>" : "<style ", 1);
							repeat ($urandom_range(0, 12))
								doc.push_back(8'($urandom_range(32, 126)));
							add_text("</style>", $urandom_range(0, 3) == 0);
						end
						9: begin
							if ($urandom_range(0, 1)) begin
								add_text("</scrip>", 0);
							end else begin
								add_text("<styl>", 0);
							end
						end
						10: doc.push_back($urandom_range(0, 1) ? ASC_LT : ASC_GT);
						11: doc.push_back(8'($urandom_range(0, 255)));
						12: add_text("</SCRIPT>", 0);
						default: begin
							repeat ($urandom_range(1, 6)) begin
								ch = 8'($urandom_range(33, 126));
								if (ch == ASC_LT || ch == ASC_GT) begin
									ch = "x";
								end
								doc.push_back(ch);
							end
						end
					endcase
				end
			end
			for (int k = 0; k < doc.size(); k++) begin
				send(doc[k], k == doc.size() - 1, 1'b0, 8'h00);
			end
			n_rand += doc.size();
		end
		s_tvalid <= 1'b0;

		// drain, then watch for stray results
		@(posedge clk);
		while (text_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (n_faults == 0) begin
			$display("** html_tag_stripper_core: PASSED **");
		end else begin
			$display("** html_tag_stripper_core: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10000000;
		$display("** html_tag_stripper_core: FAILED **");
		$finish;
	end

endmodule
